/* src/assert_macros.svh */
// Assertion macros shared by the tangent-space RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* src/vts_pkg.sv */
// Types, constants and codes of the vertex tangent-space block
`default_nettype none
package vts_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int LIMIT_BITS    = 30;
  localparam int MUL_W         = LIMIT_BITS + 1;
  localparam int Q_MAX         = ((1 << OUT_FRAC_BITS) > 32767) ? 32767 : (1 << OUT_FRAC_BITS);

  localparam int DS_W     = 64;
  localparam int DS_DEN_W = 31;
  localparam int DS_REM_W = 36;
  localparam int DS_CNT_W = 6;

  localparam int CFG_ADDR_W = 3;

  localparam logic [1:0] TOPO_LIST  = 2'd0;
  localparam logic [1:0] TOPO_STRIP = 2'd1;
  localparam logic [1:0] TOPO_LINES = 2'd2;

  localparam logic CFG_TOPOLOGY = 1'b0;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SHIFT_E,
    S_SHIFT_D,
    S_MUL,
    S_ACC,
    S_CHECK,
    S_VLOAD,
    S_VSHIFT,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT,
    S_SQRT_WAIT,
    S_DIV,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* src/vts_divsqrt.sv */
// Shared iterative unit: restoring divide (one bit a cycle) and square root (two radicand bits a cycle)
`default_nettype none
`include "assert_macros.svh"
module vts_divsqrt
  import vts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ds_ctrl_t            ctrl,
  input  logic [DS_W-1:0]     arg_a,
  input  logic [DS_DEN_W-1:0] arg_b,
  output ds_stat_t            stat,
  output logic [DS_W-1:0]     result
);

  logic                busy;
  logic                done;
  ds_op_t              op;
  logic [DS_W-1:0]     work;
  logic [DS_W-1:0]     work_next;
  logic [DS_W-1:0]     quot;
  logic [DS_W-1:0]     quot_next;
  logic [DS_REM_W-1:0] rem;
  logic [DS_REM_W-1:0] rem_next;
  logic [DS_REM_W-1:0] rem_s;
  logic [DS_REM_W-1:0] trial;
  logic [DS_DEN_W-1:0] den;
  logic [DS_CNT_W-1:0] cnt;
  logic                take;

  always_comb begin
    if (op == DS_SQRT) begin
      rem_s     = {rem[DS_REM_W-3:0], work[DS_W-1 -: 2]};
      trial     = {quot[DS_REM_W-3:0], 2'b01};
      work_next = {work[DS_W-3:0], 2'b00};
    end else begin
      rem_s     = {rem[DS_REM_W-2:0], work[DS_W-1]};
      trial     = DS_REM_W'(den);
      work_next = {work[DS_W-2:0], 1'b0};
    end
    take      = (rem_s >= trial);
    rem_next  = take ? (rem_s - trial) : rem_s;
    quot_next = {quot[DS_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      op   <= ctrl.op;
      work <= arg_a;
      den  <= arg_b;
      rem  <= '0;
      quot <= '0;
      cnt  <= (ctrl.op == DS_SQRT) ? DS_CNT_W'(DS_W / 2 - 1) : DS_CNT_W'(DS_W - 1);
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
      quot <= quot_next;
      cnt  <= cnt - 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = quot;

  `ASSERT_IMPL(a_no_restart, clk, rst, ctrl.start, !busy)
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPL(a_busy_from_start, clk, rst, $rose(busy), $past(ctrl.start))

endmodule
`default_nettype wire

/* src/vertex_tangent_space.sv */
// Top level: vertex window, sequencer, shared multiplier and output register
//
//   channel  direction  handshake            payload
//   in       to block   in_valid/in_stall    pos_x..tex_v, mesh_start
//   out      from block out_valid/out_stall  tangent_*, bitangent_*, degenerate, last_of_run
//   cfg      to block   APB psel/penable     topology at byte address 0
//
// A vertex that completes a triangle runs one or three corner jobs; a job ends early when the
// UV determinant or the tangent is zero, and is longest with both vectors normalised; its
// length is set by the shared divide/root unit (64 steps a quotient, 32 a root, three quotients
// and one root per vector) and the single 31x31 multiplier (14 products).
// in_stall is high from an accepted vertex that starts a job until its last result sits in the output register.
// A full output register under out_stall holds the sequencer at its emit step.
// Reset clears the vertex count, the topology and the output valid.
`default_nettype none
`include "assert_macros.svh"
module vertex_tangent_space
  import vts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic signed [31:0]    tex_u,
  input  logic signed [31:0]    tex_v,
  input  logic                  mesh_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    tangent_x,
  output logic signed [15:0]    tangent_y,
  output logic signed [15:0]    tangent_z,
  output logic signed [15:0]    bitangent_x,
  output logic signed [15:0]    bitangent_y,
  output logic signed [15:0]    bitangent_z,
  output logic                  degenerate,
  output logic                  last_of_run
);

  state_t state;
  state_t state_next;

  logic [1:0] topology;
  logic [1:0] vertex_count;
  logic [1:0] cnt0;
  logic [1:0] cnt1;
  logic [1:0] jobs_left;
  logic       rev;
  logic       vsel;
  logic       deg;
  logic [3:0] step;
  logic       cfg_we;
  logic       in_take;
  logic       start_job;
  logic       emit_ok;

  logic signed [31:0] cpx [3];
  logic signed [31:0] cpy [3];
  logic signed [31:0] cpz [3];
  logic signed [31:0] ctu [3];
  logic signed [31:0] ctv [3];

  logic signed [31:0] pa_x, pa_y, pa_z, ta_u, ta_v;
  logic signed [31:0] pc_x, pc_y, pc_z, tc_u, tc_v;
  logic signed [31:0] sub_a;
  logic signed [31:0] sub_b;
  logic signed [32:0] diff;
  logic        [32:0] dmag;

  logic [32:0] gm [10];
  logic        gn [10];
  logic        e_big;
  logic        d_big;

  logic [3:0]              ma;
  logic [3:0]              mb;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [62:0]      tmp;
  logic signed [62:0]      res [7];
  logic                    det_neg;

  logic [62:0] vm [3];
  logic        vs [3];
  logic signed [62:0] vval [3];
  logic        v_zero;
  logic        v_big;
  logic        v_small;
  logic [61:0] sum;
  logic [DS_DEN_W-1:0] len;

  logic signed [15:0] ot [3];
  logic signed [15:0] ob [3];
  logic [15:0]        qv;
  logic signed [15:0] qs;

  ds_ctrl_t            ds_ctrl;
  ds_stat_t            ds_stat;
  logic [DS_W-1:0]     ds_a;
  logic [DS_W-1:0]     ds_res;

  localparam logic signed [15:0] QMAX_S = 16'(Q_MAX);

  vts_divsqrt u_ds (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ds_ctrl),
    .arg_a  (ds_a),
    .arg_b  (len),
    .stat   (ds_stat),
    .result (ds_res)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_TOPOLOGY);
  assign prdata = (paddr[2] == CFG_TOPOLOGY) ? {30'd0, topology} : 32'd0;

  assign in_take   = in_valid && !in_stall;
  assign cnt0      = mesh_start ? 2'd0 : vertex_count;
  assign cnt1      = (topology == TOPO_LIST && cnt0 == 2'd3) ? 2'd0 : cnt0;
  assign start_job = in_take && (topology < TOPO_LINES) && (cnt1 >= 2'd2);
  assign emit_ok   = !out_valid || !out_stall;

  // corner a and c swap for the single sliding-window corner
  assign pa_x = rev ? cpx[2] : cpx[0];
  assign pa_y = rev ? cpy[2] : cpy[0];
  assign pa_z = rev ? cpz[2] : cpz[0];
  assign ta_u = rev ? ctu[2] : ctu[0];
  assign ta_v = rev ? ctv[2] : ctv[0];
  assign pc_x = rev ? cpx[0] : cpx[2];
  assign pc_y = rev ? cpy[0] : cpy[2];
  assign pc_z = rev ? cpz[0] : cpz[2];
  assign tc_u = rev ? ctu[0] : ctu[2];
  assign tc_v = rev ? ctv[0] : ctv[2];

  always_comb begin
    case (step)
      4'd0:    begin sub_a = cpx[1]; sub_b = pa_x; end
      4'd1:    begin sub_a = cpy[1]; sub_b = pa_y; end
      4'd2:    begin sub_a = cpz[1]; sub_b = pa_z; end
      4'd3:    begin sub_a = pc_x;   sub_b = pa_x; end
      4'd4:    begin sub_a = pc_y;   sub_b = pa_y; end
      4'd5:    begin sub_a = pc_z;   sub_b = pa_z; end
      4'd6:    begin sub_a = ctu[1]; sub_b = ta_u; end
      4'd7:    begin sub_a = ctv[1]; sub_b = ta_v; end
      4'd8:    begin sub_a = tc_u;   sub_b = ta_u; end
      default: begin sub_a = tc_v;   sub_b = ta_v; end
    endcase
    diff = {sub_a[31], sub_a} - {sub_b[31], sub_b};
    dmag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_comb begin
    e_big = 1'b0;
    d_big = 1'b0;
    for (int i = 0; i < 6; i++) e_big = e_big | (|gm[i][32:LIMIT_BITS]);
    for (int i = 6; i < 10; i++) d_big = d_big | (|gm[i][32:LIMIT_BITS]);
  end

  always_comb begin
    v_zero  = 1'b1;
    v_big   = 1'b0;
    v_small = 1'b1;
    for (int i = 0; i < 3; i++) begin
      vval[i] = vsel ? res[4 + i] : res[1 + i];
      v_zero  = v_zero & (vm[i] == '0);
      v_big   = v_big | (|vm[i][62:LIMIT_BITS]);
      v_small = v_small & !vm[i][LIMIT_BITS-1];
    end
  end

  // product schedule: det, then T per axis, then B per axis, two products a pair
  always_comb begin
    case (step)
      4'd0:    begin ma = 4'd6; mb = 4'd9; end
      4'd1:    begin ma = 4'd7; mb = 4'd8; end
      4'd2:    begin ma = 4'd9; mb = 4'd0; end
      4'd3:    begin ma = 4'd7; mb = 4'd3; end
      4'd4:    begin ma = 4'd9; mb = 4'd1; end
      4'd5:    begin ma = 4'd7; mb = 4'd4; end
      4'd6:    begin ma = 4'd9; mb = 4'd2; end
      4'd7:    begin ma = 4'd7; mb = 4'd5; end
      4'd8:    begin ma = 4'd6; mb = 4'd3; end
      4'd9:    begin ma = 4'd8; mb = 4'd0; end
      4'd10:   begin ma = 4'd6; mb = 4'd4; end
      4'd11:   begin ma = 4'd8; mb = 4'd1; end
      4'd12:   begin ma = 4'd6; mb = 4'd5; end
      default: begin ma = 4'd8; mb = 4'd2; end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (start_job) state_next = S_DIFF;
      S_DIFF:      if (step == 4'd9) state_next = S_SHIFT_E;
      S_SHIFT_E:   if (!e_big) state_next = S_SHIFT_D;
      S_SHIFT_D:   if (!d_big) state_next = S_MUL;
      S_MUL:       state_next = S_ACC;
      S_ACC:       state_next = (step == 4'd13) ? S_CHECK : S_MUL;
      S_CHECK:     state_next = (res[0] == '0) ? S_EMIT : S_VLOAD;
      S_VLOAD:     state_next = S_VSHIFT;
      S_VSHIFT: begin
        if (v_zero) state_next = S_EMIT;
        else if (!v_big && !v_small) state_next = S_SQ_MUL;
      end
      S_SQ_MUL:    state_next = S_SQ_ACC;
      S_SQ_ACC:    state_next = (step == 4'd2) ? S_SQRT : S_SQ_MUL;
      S_SQRT:      state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: if (ds_stat.done) state_next = S_DIV;
      S_DIV:       state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (ds_stat.done) begin
          if (step != 4'd2) state_next = S_DIV;
          else state_next = vsel ? S_EMIT : S_VLOAD;
        end
      end
      S_EMIT: begin
        if (emit_ok) state_next = (jobs_left != 2'd0) ? S_DIFF : S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // control outputs and shared-unit operands
  always_comb begin
    in_stall   = (state != S_IDLE);
    ds_ctrl.start = (state == S_SQRT) || (state == S_DIV);
    ds_ctrl.op    = (state == S_SQRT) ? DS_SQRT : DS_DIV;
    ds_a = (state == S_SQRT) ? DS_W'(sum)
         : ((DS_W'(vm[step[1:0]][LIMIT_BITS-1:0]) << OUT_FRAC_BITS) + DS_W'(len >> 1));
    if (state == S_SQ_MUL) begin
      mul_a = {1'b0, vm[step[1:0]][LIMIT_BITS-1:0]};
      mul_b = {1'b0, vm[step[1:0]][LIMIT_BITS-1:0]};
    end else begin
      mul_a = gn[ma] ? -$signed({1'b0, gm[ma][LIMIT_BITS-1:0]})
                     :  $signed({1'b0, gm[ma][LIMIT_BITS-1:0]});
      mul_b = gn[mb] ? -$signed({1'b0, gm[mb][LIMIT_BITS-1:0]})
                     :  $signed({1'b0, gm[mb][LIMIT_BITS-1:0]});
    end
    qv = (ds_res > DS_W'(Q_MAX)) ? 16'(Q_MAX) : ds_res[15:0];
    qs = vs[step[1:0]] ? -$signed(qv) : $signed(qv);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      topology     <= TOPO_LIST;
      vertex_count <= 2'd0;
      out_valid    <= 1'b0;
      jobs_left    <= 2'd0;
      rev          <= 1'b0;
      vsel         <= 1'b0;
      deg          <= 1'b0;
      step         <= 4'd0;
    end else begin
      state <= state_next;
      if (cfg_we) topology <= pwdata[1:0];
      if (state == S_EMIT && emit_ok) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (topology >= TOPO_LINES) vertex_count <= 2'd0;
            else if (cnt1 == 2'd3) vertex_count <= 2'd3;
            else if (cnt1 == 2'd2) vertex_count <= (topology == TOPO_LIST) ? 2'd0 : 2'd3;
            else vertex_count <= cnt1 + 2'd1;
            rev       <= (cnt1 == 2'd3);
            jobs_left <= (start_job && cnt1 != 2'd3) ? 2'd2 : 2'd0;
            step      <= 4'd0;
            deg       <= 1'b0;
          end
        end
        S_DIFF:    step <= (step == 4'd9) ? 4'd0 : step + 4'd1;
        S_SHIFT_D: if (!d_big) step <= 4'd0;
        S_ACC:     step <= step + 4'd1;
        S_CHECK: begin
          if (res[0] == '0) deg <= 1'b1;
          vsel <= 1'b0;
        end
        S_VSHIFT: begin
          if (v_zero) deg <= 1'b1;
          step <= 4'd0;
        end
        S_SQ_ACC:  step <= (step == 4'd2) ? 4'd0 : step + 4'd1;
        S_DIV_WAIT: begin
          if (ds_stat.done) begin
            if (step == 4'd2) begin
              step <= 4'd0;
              vsel <= 1'b1;
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        S_EMIT: begin
          if (emit_ok && jobs_left != 2'd0) begin
            jobs_left <= jobs_left - 2'd1;
            step      <= 4'd0;
            deg       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (in_take && topology < TOPO_LINES) begin
          if (cnt1 == 2'd3) begin
            cpx[0] <= cpx[1]; cpx[1] <= cpx[2]; cpx[2] <= pos_x;
            cpy[0] <= cpy[1]; cpy[1] <= cpy[2]; cpy[2] <= pos_y;
            cpz[0] <= cpz[1]; cpz[1] <= cpz[2]; cpz[2] <= pos_z;
            ctu[0] <= ctu[1]; ctu[1] <= ctu[2]; ctu[2] <= tex_u;
            ctv[0] <= ctv[1]; ctv[1] <= ctv[2]; ctv[2] <= tex_v;
          end else begin
            cpx[cnt1] <= pos_x;
            cpy[cnt1] <= pos_y;
            cpz[cnt1] <= pos_z;
            ctu[cnt1] <= tex_u;
            ctv[cnt1] <= tex_v;
          end
        end
      end
      S_DIFF: begin
        gm[step] <= dmag;
        gn[step] <= diff[32];
      end
      S_SHIFT_E: begin
        if (e_big) for (int i = 0; i < 6; i++) gm[i] <= gm[i] >> 1;
      end
      S_SHIFT_D: begin
        if (d_big) for (int i = 6; i < 10; i++) gm[i] <= gm[i] >> 1;
      end
      S_ACC: begin
        if (!step[0]) tmp <= 63'(prod);
        else res[step[3:1]] <= tmp - 63'(prod);
      end
      S_CHECK: det_neg <= res[0][62];
      S_VLOAD: begin
        for (int i = 0; i < 3; i++) begin
          vm[i] <= vval[i][62] ? 63'(-vval[i]) : 63'(vval[i]);
          vs[i] <= vval[i][62] ^ det_neg;
        end
      end
      S_VSHIFT: begin
        if (!v_zero) begin
          if (v_big) for (int i = 0; i < 3; i++) vm[i] <= vm[i] >> 1;
          else if (v_small) for (int i = 0; i < 3; i++) vm[i] <= vm[i] << 1;
        end
      end
      S_SQ_ACC: sum <= ((step == 4'd0) ? 62'd0 : sum) + 62'(prod);
      S_SQRT_WAIT: if (ds_stat.done) len <= ds_res[DS_DEN_W-1:0];
      S_DIV_WAIT: begin
        if (ds_stat.done) begin
          if (vsel) ob[step[1:0]] <= qs;
          else ot[step[1:0]] <= qs;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          tangent_x   <= deg ? 16'sd0 : ot[0];
          tangent_y   <= deg ? 16'sd0 : ot[1];
          tangent_z   <= deg ? 16'sd0 : ot[2];
          bitangent_x <= deg ? 16'sd0 : ob[0];
          bitangent_y <= deg ? 16'sd0 : ob[1];
          bitangent_z <= deg ? 16'sd0 : ob[2];
          degenerate  <= deg;
          last_of_run <= (jobs_left == 2'd0);
          if (!rev) begin
            cpx[0] <= cpx[1]; cpx[1] <= cpx[2]; cpx[2] <= cpx[0];
            cpy[0] <= cpy[1]; cpy[1] <= cpy[2]; cpy[2] <= cpy[0];
            cpz[0] <= cpz[1]; cpz[1] <= cpz[2]; cpz[2] <= cpz[0];
            ctu[0] <= ctu[1]; ctu[1] <= ctu[2]; ctu[2] <= ctu[0];
            ctv[0] <= ctv[1]; ctv[1] <= ctv[2]; ctv[2] <= ctv[0];
          end
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_deg_zero, clk, rst, out_valid && degenerate, tangent_x == 0 && bitangent_z == 0)
  `ASSERT_IMPL(a_rise_from_emit, clk, rst, $rose(out_valid), $past(state) == S_EMIT)
  `ASSERT_IMPL(a_idle_no_jobs, clk, rst, state == S_IDLE, jobs_left == 2'd0)
  `ASSERT_IMPL(a_range, clk, rst, out_valid, tangent_x <= QMAX_S && tangent_x >= -QMAX_S)

endmodule
`default_nettype wire

/* test/vertex_tangent_space_tb.sv */
// Testbench for vertex_tangent_space: random vertex streams checked against a tangent predictor
module vertex_tangent_space_tb;
  import vts_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic               ms;
  } vertex_t;

  typedef struct {
    logic signed [15:0] tx, ty, tz, bx, by, bz;
    logic               deg, last;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
  logic mesh_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] tangent_x, tangent_y, tangent_z;
  logic signed [15:0] bitangent_x, bitangent_y, bitangent_z;
  logic degenerate, last_of_run;

  vertex_tangent_space dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_t pending_verts[$];
  frame_t  expected_frames[$];
  int      idle_pct = 0, stall_pct = 0, phase_id = 0;
  int      mismatches = 0, quiet_cycles = 0, hold_left = 0;
  bit      hold_done = 1'b0, vert_taken = 1'b0;

  // predictor state
  longint  win_pos[9];
  longint  win_tex[6];
  int      win_count = 0;
  logic [1:0] topo_shadow = TOPO_LIST;

  function automatic void add_vertex(vertex_t v);
    pending_verts.insert(pending_verts.size(), v);
  endfunction

  function automatic void add_frame(frame_t f);
    expected_frames.insert(expected_frames.size(), f);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic void shift_group(inout longint v[6], input int n, input bit grow);
    longint unsigned m, a;
    int l;
    m = 0;
    l = 0;
    for (int i = 0; i < n; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
    if (m == 0) return;
    while (m != 0) begin
      l++;
      m = m >> 1;
    end
    for (int i = 0; i < n; i++) begin
      a = magnitude(v[i]);
      if (l > LIMIT_BITS) a = a >> (l - LIMIT_BITS);
      else if (grow) a = a << (LIMIT_BITS - l);
      v[i] = v[i] < 0 ? -longint'(a) : longint'(a);
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vector(input longint v[6], output logic signed [15:0] o[3]);
    longint unsigned sum, len, q;
    sum = 0;
    o[0] = 0; o[1] = 0; o[2] = 0;
    if (v[0] == 0 && v[1] == 0 && v[2] == 0) return 1'b0;
    shift_group(v, 3, 1'b1);
    for (int i = 0; i < 3; i++) sum += magnitude(v[i]) * magnitude(v[i]);
    len = int_sqrt(sum);
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((magnitude(v[i]) << OUT_FRAC_BITS) + len / 2) / len;
      if (q > Q_MAX) q = Q_MAX;
      o[i] = v[i] < 0 ? -16'(q) : 16'(q);
    end
    return 1'b1;
  endfunction

  function automatic frame_t corner_frame(int a, int b, int c, bit last);
    longint e[6], d[6], t[6], bt[6];
    longint det, sg;
    logic signed [15:0] ot[3], ob[3];
    bit ok;
    frame_t f;
    for (int i = 0; i < 6; i++) begin
      d[i] = 0; t[i] = 0; bt[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      e[i]     = win_pos[b*3+i] - win_pos[a*3+i];
      e[3+i]   = win_pos[c*3+i] - win_pos[a*3+i];
    end
    d[0] = win_tex[b*2]   - win_tex[a*2];
    d[1] = win_tex[b*2+1] - win_tex[a*2+1];
    d[2] = win_tex[c*2]   - win_tex[a*2];
    d[3] = win_tex[c*2+1] - win_tex[a*2+1];
    shift_group(e, 6, 1'b0);
    shift_group(d, 4, 1'b0);
    det = d[0]*d[3] - d[1]*d[2];
    sg = det > 0 ? 1 : -1;
    for (int i = 0; i < 3; i++) begin
      t[i]  = sg * (d[3]*e[i] - d[1]*e[3+i]);
      bt[i] = sg * (d[0]*e[3+i] - d[2]*e[i]);
    end
    ok = det != 0;
    if (ok) ok = unit_vector(t, ot);
    if (ok) ok = unit_vector(bt, ob);
    if (ok) begin
      f.tx = ot[0]; f.ty = ot[1]; f.tz = ot[2];
      f.bx = ob[0]; f.by = ob[1]; f.bz = ob[2];
    end else begin
      f.tx = 0; f.ty = 0; f.tz = 0; f.bx = 0; f.by = 0; f.bz = 0;
    end
    f.deg = !ok;
    f.last = last;
    return f;
  endfunction

  task automatic predict_vertex(vertex_t v);
    int slot;
    if (v.ms) win_count = 0;
    if (topo_shadow >= TOPO_LINES) begin
      win_count = 0;
      return;
    end
    if (topo_shadow == TOPO_LIST && win_count >= 3) win_count = 0;
    if (win_count >= 3) begin
      for (int i = 0; i < 6; i++) win_pos[i] = win_pos[i+3];
      for (int i = 0; i < 4; i++) win_tex[i] = win_tex[i+2];
      slot = 2;
    end else begin
      slot = win_count;
    end
    win_pos[slot*3]   = v.px;
    win_pos[slot*3+1] = v.py;
    win_pos[slot*3+2] = v.pz;
    win_tex[slot*2]   = v.tu;
    win_tex[slot*2+1] = v.tv;
    if (win_count >= 3) begin
      add_frame(corner_frame(2, 1, 0, 1'b1));
      return;
    end
    win_count++;
    if (win_count < 3) return;
    for (int k = 0; k < 3; k++)
      add_frame(corner_frame(k, (k+1)%3, (k+2)%3, k == 2));
    if (topo_shadow == TOPO_LIST) win_count = 0;
  endtask

  // accept, predict, check
  always @(posedge clk) begin
    frame_t e;
    vert_taken = 1'b0;
    if (!rst) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        predict_vertex('{pos_x, pos_y, pos_z, tex_u, tex_v, mesh_start});
        vert_taken = 1'b1;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: tangent %0d %0d %0d",
                                         tangent_x, tangent_y, tangent_z);
        end else begin
          e = expected_frames.pop_front();
          if (e.tx !== tangent_x || e.ty !== tangent_y || e.tz !== tangent_z ||
              e.bx !== bitangent_x || e.by !== bitangent_y || e.bz !== bitangent_z ||
              e.deg !== degenerate || e.last !== last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp T %0d %0d %0d B %0d %0d %0d deg %0d last %0d",
                       e.tx, e.ty, e.tz, e.bx, e.by, e.bz, e.deg, e.last,
                       " | got T %0d %0d %0d B %0d %0d %0d deg %0d last %0d",
                       tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                       bitangent_z, degenerate, last_of_run);
          end
        end
      end
      if (quiet_cycles >= 30000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    vertex_t v;
    if (!rst && (!in_valid || vert_taken)) begin
      if (pending_verts.size() > 0 && $urandom_range(99) >= idle_pct) begin
        v = pending_verts.pop_front();
        pos_x <= v.px; pos_y <= v.py; pos_z <= v.pz;
        tex_u <= v.tu; tex_v <= v.tv; mesh_start <= v.ms;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off once, in the pressure phase
  always @(negedge clk) begin
    if (phase_id == 1 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  task automatic write_topology(logic [1:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= CFG_ADDR_W'(CFG_TOPOLOGY); pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    topo_shadow = val;
  endtask

  function automatic logic signed [31:0] pick_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed(32'($urandom_range(2097151))) - 32'sd1048576;
      2: return $signed(32'($urandom_range(8))) - 32'sd4;
      default: begin
        case ($urandom_range(2))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t v;
    int kind, r;
    r = $urandom_range(99);
    kind = r < 40 ? 1 : r < 60 ? 0 : r < 75 ? 2 : r < 90 ? 1 : 3;
    v.px = pick_coord(kind); v.py = pick_coord(kind); v.pz = pick_coord(kind);
    v.tu = r >= 75 && r < 90 ? 32'sd65536 : pick_coord(kind);
    v.tv = r >= 75 && r < 90 ? 32'sd0 : pick_coord(kind);
    v.ms = $urandom_range(7) == 0;
    return v;
  endfunction

  task automatic run_phase(int id, logic [1:0] topo, int idle, int stall, int n);
    write_topology(topo);
    idle_pct = idle;
    stall_pct = stall;
    phase_id = id;
    for (int i = 0; i < n; i++) add_vertex(random_vertex());
    wait (pending_verts.size() == 0 && !in_valid && expected_frames.size() == 0);
    repeat (2000) @(posedge clk);
  endtask

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // extremes
    add_vertex('{MAXV, MAXV, MINV, MAXV, MINV, 1'b1});
    add_vertex('{MINV, MINV, MAXV, MINV, MINV, 1'b0});
    add_vertex('{0, MAXV, 0, MAXV, MAXV, 1'b0});
    // plain right triangle
    add_vertex('{0, 0, 0, 0, 0, 1'b0});
    add_vertex('{32'sd65536, 0, 0, 32'sd65536, 0, 1'b0});
    add_vertex('{0, 32'sd65536, 0, 0, 32'sd65536, 1'b0});
    // zero UV determinant
    add_vertex('{1, 2, 3, 5, 5, 1'b0});
    add_vertex('{7, -9, 4, 5, 5, 1'b0});
    add_vertex('{-3, 8, 1, 5, 5, 1'b0});
    // coincident positions, zero-length vectors
    add_vertex('{42, 42, 42, 0, 0, 1'b0});
    add_vertex('{42, 42, 42, 100, 0, 1'b0});
    add_vertex('{42, 42, 42, 0, 100, 1'b0});
    // restart of a part mid-triangle
    add_vertex('{10, 20, 30, 1, 2, 1'b0});
    add_vertex('{-10, 5, 3, 9, -4, 1'b0});
    add_vertex('{100, -200, 300, -7, 11, 1'b1});
    add_vertex('{-50, 60, -70, 13, 2, 1'b0});
    add_vertex('{1, -1, 1, -1, 1, 1'b0});
    wait (pending_verts.size() == 0 && !in_valid && expected_frames.size() == 0);
    repeat (4) @(posedge clk);
    run_phase(0, TOPO_LIST, 0, 0, 50);
    run_phase(1, TOPO_STRIP, 0, 0, 70);
    run_phase(2, TOPO_LIST, 72, 0, 70);
    run_phase(3, TOPO_STRIP, 0, 72, 70);
    run_phase(4, TOPO_LINES, 8, 8, 20);
    run_phase(5, TOPO_STRIP, 8, 8, 60);
    run_phase(6, TOPO_LIST, 8, 8, 30);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* vertex_tangent_space.f */
+incdir+src
src/vts_pkg.sv
src/vts_divsqrt.sv
src/vertex_tangent_space.sv
test/vertex_tangent_space_tb.sv
